// ----- sv/tsq_pkg.sv -----
// Shared types and constants for the two-stack queue.
// Used by two_stack_queue_core.
package tsq_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_DATA_WIDTH  = 32;

  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } qstat_t;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

endpackage

// ----- sv/tsq_stack_ram.sv -----
// Stack storage: one write port, one read port with registered read data.
// No dependencies.
module tsq_stack_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/two_stack_queue_core.sv -----
// Top level of the two-stack FIFO queue.
// Depends on tsq_pkg and tsq_stack_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, mode, data_in): mode 0 pushes data_in,
//   mode 1 pops the oldest word. Output channel (out_valid/out_ready,
//   status, data_out, count): exactly one result per input transfer, in order.
//   cfg_wr_en/cfg_wr_data write the capacity register; write only when idle.
// Result path: an enqueue, or a dequeue on an empty queue, loads the result
//   register as the input is taken; a dequeue with a non-empty output stack
//   pops it in S_POP; otherwise the output stack is refilled in S_MOVE.
//   The refill moves one word per cycle through the input stack's read port
//   and the output stack's write port. A new item is taken once the result
//   register is free or being emptied, so enqueues run one per cycle while
//   the receiver takes each result.
// Reset: both stacks become empty and capacity returns to 16; no memory
//   clearing pass is needed.
// Receiver stall: the result stays in the output register and in_ready drops
//   until it is taken.
module two_stack_queue_core #(
  parameter int STACK_DEPTH = tsq_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = tsq_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [DATA_WIDTH-1:0]        data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tsq_pkg::STATUS_W-1:0] status,
  output logic [DATA_WIDTH-1:0]        data_out,
  output logic [tsq_pkg::COUNT_W-1:0]  count,
  input  logic                         cfg_wr_en,
  input  logic [tsq_pkg::CAP_W-1:0]    cfg_wr_data
);

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W   = DEPTH_W + 1;
  localparam int CMP_W   = (DEPTH_W > tsq_pkg::CAP_W) ? DEPTH_W : tsq_pkg::CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_MOVE = 3'b100
  } state_t;

  state_t                     state, state_next;
  logic [DEPTH_W-1:0]         in_depth, in_depth_next;
  logic [DEPTH_W-1:0]         out_depth, out_depth_next;
  logic                       mv_pend, mv_pend_next;
  logic [tsq_pkg::CAP_W-1:0]  capacity;

  logic                       in_we, in_re, out_we, out_re;
  logic [ADDR_W-1:0]          in_waddr, in_raddr, out_waddr, out_raddr;
  logic [DATA_WIDTH-1:0]      in_rdata, out_rdata;

  logic                       res_load;
  tsq_pkg::qstat_t            res_status;
  logic [DATA_WIDTH-1:0]      res_data;

  logic [DEPTH_W-1:0]         in_dm1, out_dm1, in_dp1;
  logic [SUM_W-1:0]           sum_next;
  logic                       full, take;

  assign in_dm1  = in_depth - DEPTH_W'(1);
  assign out_dm1 = out_depth - DEPTH_W'(1);
  assign in_dp1  = in_depth + DEPTH_W'(1);
  assign full    = (CMP_W'(in_depth) >= CMP_W'(capacity)) ||
                   (in_depth >= DEPTH_W'(STACK_DEPTH));
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;
  assign sum_next = SUM_W'(in_depth_next) + SUM_W'(out_depth_next);

  assign in_waddr  = in_depth[ADDR_W-1:0];
  assign in_raddr  = in_dm1[ADDR_W-1:0];
  assign out_waddr = out_depth[ADDR_W-1:0];
  assign out_raddr = out_dm1[ADDR_W-1:0];

  tsq_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_WIDTH)) u_in_stack (
    .clk     (clk),
    .wr_en   (in_we),
    .wr_addr (in_waddr),
    .wr_data (data_in),
    .rd_en   (in_re),
    .rd_addr (in_raddr),
    .rd_data (in_rdata)
  );

  tsq_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_WIDTH)) u_out_stack (
    .clk     (clk),
    .wr_en   (out_we),
    .wr_addr (out_waddr),
    .wr_data (in_rdata),
    .rd_en   (out_re),
    .rd_addr (out_raddr),
    .rd_data (out_rdata)
  );

  always_comb begin
    state_next     = state;
    in_depth_next  = in_depth;
    out_depth_next = out_depth;
    mv_pend_next   = mv_pend;
    in_we          = 1'b0;
    in_re          = 1'b0;
    out_we         = 1'b0;
    out_re         = 1'b0;
    res_load       = 1'b0;
    res_status     = tsq_pkg::STATUS_OK;
    res_data       = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (mode == tsq_pkg::MODE_ENQ) begin
            res_load = 1'b1;
            if (full) begin
              res_status = tsq_pkg::STATUS_FULL;
            end else begin
              in_we         = 1'b1;
              in_depth_next = in_dp1;
            end
          end else if (out_depth != '0) begin
            out_re         = 1'b1;
            out_depth_next = out_dm1;
            state_next     = S_POP;
          end else if (in_depth == '0) begin
            res_load   = 1'b1;
            res_status = tsq_pkg::STATUS_EMPTY;
          end else begin
            mv_pend_next = 1'b0;
            state_next   = S_MOVE;
          end
        end
      end
      S_POP: begin
        res_load   = 1'b1;
        res_data   = out_rdata;
        state_next = S_IDLE;
      end
      S_MOVE: begin
        // read next input entry while writing the previous one; the oldest
        // word is returned directly instead of being written
        in_re        = (in_depth != '0);
        mv_pend_next = (in_depth != '0);
        if (in_depth != '0) begin
          in_depth_next = in_dm1;
        end
        if (mv_pend) begin
          if (in_depth == '0) begin
            res_load   = 1'b1;
            res_data   = in_rdata;
            state_next = S_IDLE;
          end else begin
            out_we         = 1'b1;
            out_depth_next = out_depth + DEPTH_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_depth  <= '0;
      out_depth <= '0;
      mv_pend   <= 1'b0;
      capacity  <= tsq_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_depth  <= in_depth_next;
      out_depth <= out_depth_next;
      mv_pend   <= mv_pend_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status   <= res_status;
      data_out <= res_data;
      count    <= tsq_pkg::COUNT_W'(sum_next);
    end
  end

endmodule
